// File: sv/uart_spi_bridge_command_parser_defines.svh
// assertion macros for the command parser checker
// used by ubcp_checker.sv, expects clk and rst_n in scope
`ifndef UART_SPI_BRIDGE_COMMAND_PARSER_DEFINES_SVH
`define UART_SPI_BRIDGE_COMMAND_PARSER_DEFINES_SVH

// generic clocked assertion, disabled during reset
`define UBCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a stalled output beat keeps its payload
`define UBCP_ASSERT_HOLD(lbl, vld, rdy, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error("beat changed while stalled");

`endif

// File: sv/ubcp_pkg.sv
// shared types and constants of the command parser
// no dependencies
`default_nettype none

package ubcp_pkg;

    // command bytes
    localparam logic [7:0] CMD_SELECT   = 8'h73; // 's'
    localparam logic [7:0] CMD_UNSELECT = 8'h75; // 'u'
    localparam logic [7:0] CMD_ECHO     = 8'h65; // 'e'
    localparam logic [7:0] CMD_LINE_A   = 8'h61; // 'a'
    localparam logic [7:0] CMD_LINE_B   = 8'h62; // 'b'
    localparam logic [7:0] CMD_MODE     = 8'h6d; // 'm'
    localparam logic [1:0] MODE_MAX     = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ECHO,
        PH_LINEA,
        PH_LINEB,
        PH_MODE,
        PH_WRITE,
        PH_XCHG
    } phase_t;

    // work handed from front to back
    typedef enum logic [3:0] {
        OP_NOP,
        OP_SEL_SET,
        OP_SEL_CLR,
        OP_BAD,
        OP_ECHO,
        OP_LINE_A,
        OP_LINE_B,
        OP_MODE,
        OP_WRITE,
        OP_XCHG
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  data;
        logic [7:0]  miso;
    } op_t;

    // result beat, last member lands in bit 0
    typedef struct packed {
        logic        bad_command;
        logic [1:0]  bus_mode;
        logic        line_b;
        logic        line_a;
        logic        select_active;
        logic [7:0]  mosi_byte;
        logic        spi_valid;
        logic [7:0]  reply_byte;
        logic        reply_valid;
    } result_t;

endpackage

`default_nettype wire

// File: sv/ubcp_fifo.sv
// small register queue between parser front and back
// no package dependency
`default_nettype none

module ubcp_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/ubcp_front.sv
// parser front: tracks command phase and classifies each host byte
// depends on ubcp_pkg
`default_nettype none

module ubcp_front
    import ubcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] host_byte,
    input  wire logic [7:0] miso_byte,
    input  wire logic       queue_full,
    output logic            in_ready,
    output logic            push,
    output op_t             op
);

    phase_t     phase_reg, phase_next;
    logic [6:0] bytes_left_reg, bytes_left_next;

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        op.kind         = OP_NOP;
        op.data         = host_byte;
        op.miso         = miso_byte;
        if (push)
        begin
            unique case (phase_reg)
                PH_ECHO:
                begin
                    op.kind    = OP_ECHO;
                    phase_next = PH_IDLE;
                end
                PH_LINEA:
                begin
                    op.kind    = OP_LINE_A;
                    phase_next = PH_IDLE;
                end
                PH_LINEB:
                begin
                    op.kind    = OP_LINE_B;
                    phase_next = PH_IDLE;
                end
                PH_MODE:
                begin
                    op.kind    = OP_MODE;
                    phase_next = PH_IDLE;
                end
                PH_WRITE, PH_XCHG:
                begin
                    op.kind         = (phase_reg == PH_XCHG) ? OP_XCHG : OP_WRITE;
                    bytes_left_next = bytes_left_reg - 1'b1;
                    if (bytes_left_next == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    priority if (host_byte[7])
                    begin
                        // run length is low six bits plus one
                        bytes_left_next = {1'b0, host_byte[5:0]} + 7'd1;
                        phase_next      = host_byte[6] ? PH_WRITE : PH_XCHG;
                    end
                    else
                    begin
                        unique case (host_byte)
                            CMD_SELECT:   op.kind = OP_SEL_SET;
                            CMD_UNSELECT: op.kind = OP_SEL_CLR;
                            CMD_ECHO:     phase_next = PH_ECHO;
                            CMD_LINE_A:   phase_next = PH_LINEA;
                            CMD_LINE_B:   phase_next = PH_LINEB;
                            CMD_MODE:     phase_next = PH_MODE;
                            default:      op.kind = OP_BAD;
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ubcp_back.sv
// parser back: applies queued ops to the pin and mode state, registers the result
// depends on ubcp_pkg
`default_nettype none

module ubcp_back
    import ubcp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic queue_empty,
    input  wire op_t  op,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_ready,
    output result_t   result
);

    logic       select_reg, select_next;
    logic       line_a_reg, line_a_next;
    logic       line_b_reg, line_b_next;
    logic [1:0] mode_reg, mode_next;
    logic       out_valid_reg, out_valid_next;
    result_t    result_reg, result_next;

    assign pop       = !queue_empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        select_next = select_reg;
        line_a_next = line_a_reg;
        line_b_next = line_b_reg;
        mode_next   = mode_reg;
        result_next = '0;
        unique case (op.kind)
            OP_SEL_SET: select_next = 1'b1;
            OP_SEL_CLR: select_next = 1'b0;
            OP_BAD:     result_next.bad_command = 1'b1;
            OP_ECHO:
            begin
                result_next.reply_valid = 1'b1;
                result_next.reply_byte  = op.data;
            end
            OP_LINE_A:  line_a_next = op.data[0];
            OP_LINE_B:  line_b_next = op.data[0];
            OP_MODE:
            begin
                if (op.data > {6'd0, MODE_MAX})
                begin
                    result_next.bad_command = 1'b1;
                end
                else
                begin
                    mode_next = op.data[1:0];
                end
            end
            OP_WRITE:
            begin
                result_next.spi_valid = 1'b1;
                result_next.mosi_byte = op.data;
            end
            OP_XCHG:
            begin
                result_next.spi_valid   = 1'b1;
                result_next.mosi_byte   = op.data;
                result_next.reply_valid = 1'b1;
                result_next.reply_byte  = op.miso;
            end
            default:
            begin
            end
        endcase
        result_next.select_active = select_next;
        result_next.line_a        = line_a_next;
        result_next.line_b        = line_b_next;
        result_next.bus_mode      = mode_next;

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg    <= 1'b0;
            line_a_reg    <= 1'b1;
            line_b_reg    <= 1'b1;
            mode_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                select_reg <= select_next;
                line_a_reg <= line_a_next;
                line_b_reg <= line_b_next;
                mode_reg   <= mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/uart_spi_bridge_command_parser.sv
// top level of the serial-host to spi byte-command parser
// depends on ubcp_pkg, ubcp_front, ubcp_fifo, ubcp_back
`default_nettype none

// Takes one host byte per beat (with the miso byte that pairs with it) and returns
// exactly one result beat per input beat, in order. The front tracks the command
// phase ('s', 'u', 'e', 'a', 'b', 'm', write runs 0xc0-0xff, exchange runs
// 0x80-0xbf) and turns each byte into an op; a QUEUE_DEPTH entry queue carries ops
// to the back, which owns chip select, lines a/b and the spi mode and fills the
// output register. Sustained rate is one beat per clock while the output is not
// held off; a result passes through the queue and the output register before it
// shows on the master side. Input stalls only when the queue is full: while the
// output is held off, ops pile up in the queue behind the output register until
// it fills.
// After reset: select off, lines a and b high, mode 0.
// reply_byte and mosi_byte read zero when their valid flag is clear; select,
// lines and mode in each beat are the values after that byte.

module uart_spi_bridge_command_parser
    import ubcp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // host_byte[7:0], miso_byte[15:8]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // reply_valid[0], reply_byte[8:1], spi_valid[9], mosi_byte[17:10],
    // select_active[18], line_a[19], line_b[20], bus_mode[22:21], bad_command[23]
    output logic [23:0]      m_tdata
);

    op_t     front_op;
    op_t     back_op;
    logic    push;
    logic    pop;
    logic    queue_full;
    logic    queue_empty;
    result_t result;

    // classify host bytes
    ubcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .host_byte  (s_tdata[7:0]),
        .miso_byte  (s_tdata[15:8]),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .op         (front_op)
    );

    // decouples front and back so each can stall on its own
    ubcp_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(op_t))
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_op),
        .full    (queue_full),
        .pop     (pop),
        .rd_data (back_op),
        .empty   (queue_empty)
    );

    // execute ops, hold the result beat
    ubcp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .op          (back_op),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result      (result)
    );

    assign m_tdata = result;

endmodule

`default_nettype wire

// File: sv/ubcp_checker.sv
// port-level checks of the command parser, bound to the top level
// depends on uart_spi_bridge_command_parser_defines.svh
`default_nettype none
`include "uart_spi_bridge_command_parser_defines.svh"

module ubcp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    `UBCP_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, m_tdata)
    `UBCP_ASSERT(a_reply_zero,
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[8:1] == 8'd0),
        "reply byte set without reply")
    `UBCP_ASSERT(a_mosi_zero,
        (m_tvalid && !m_tdata[9]) |-> (m_tdata[17:10] == 8'd0),
        "mosi byte set without transfer")
    `UBCP_ASSERT(a_bad_quiet,
        (m_tvalid && m_tdata[23]) |-> (!m_tdata[0] && !m_tdata[9]),
        "bad command with traffic")

endmodule

bind uart_spi_bridge_command_parser ubcp_checker u_checker (.*);

`default_nettype wire

// File: dv/tb_uart_spi_bridge_command_parser.sv
// testbench for uart_spi_bridge_command_parser: directed and random host byte streams
// with a cycle-free predictor in a small scoreboard class, random stalls on both sides
// depends on ubcp_pkg and the rtl of uart_spi_bridge_command_parser
`timescale 1ns / 1ps

module tb_uart_spi_bridge_command_parser;
    import ubcp_pkg::*;

    // host bytes the block has no command for, and the two run command ranges
    localparam logic [7:0] CMD_STATUS     = 8'h3f; // '?', status report is not supported
    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [7:0] BYTE_DEL       = 8'h7f;
    localparam logic [7:0] XCHG_CMD_BASE  = 8'h80; // 0x80-0xbf: exchange run
    localparam logic [7:0] WRITE_CMD_BASE = 8'hc0; // 0xc0-0xff: write-only run
    localparam logic [7:0] RUN_LEN_MASK   = 8'h3f;
    localparam int         RUN_LEN_MAX    = 64;

    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 48;  // long receiver hold-off, far beyond the queue depth
    localparam int BURST_BEATS  = 16;
    localparam int TAIL_CYCLES  = 8;

    // keeps its own copy of the parser state and the results still owed
    class bridge_scoreboard;
        phase_t     phase;
        logic [6:0] run_left;
        logic       select_q;
        logic       line_a_q;
        logic       line_b_q;
        logic [1:0] mode_q;
        result_t    expected_beats[$];
        int         n_checked;
        int         n_spi;
        int         n_reply;
        int         n_bad;
        int         errors;

        function new();
            phase    = PH_IDLE;
            run_left = '0;
            select_q = 1'b0;
            line_a_q = 1'b1;
            line_b_q = 1'b1;
            mode_q   = 2'd0;
        endfunction

        // one host byte in, one result beat out, state updated
        function result_t parse_host_byte(logic [7:0] hb, logic [7:0] mb);
            result_t r;
            r = '0;
            case (phase)
                PH_ECHO:
                begin
                    r.reply_valid = 1'b1;
                    r.reply_byte  = hb;
                    phase = PH_IDLE;
                end
                PH_LINEA:
                begin
                    line_a_q = hb[0];
                    phase = PH_IDLE;
                end
                PH_LINEB:
                begin
                    line_b_q = hb[0];
                    phase = PH_IDLE;
                end
                PH_MODE:
                begin
                    if (hb > MODE_MAX)
                        r.bad_command = 1'b1;
                    else
                        mode_q = hb[1:0];
                    phase = PH_IDLE;
                end
                PH_WRITE, PH_XCHG:
                begin
                    // select does not gate the transfer
                    r.spi_valid = 1'b1;
                    r.mosi_byte = hb;
                    if (phase == PH_XCHG)
                    begin
                        r.reply_valid = 1'b1;
                        r.reply_byte  = mb;
                    end
                    run_left = run_left - 7'd1;
                    if (run_left == 7'd0)
                        phase = PH_IDLE;
                end
                default:
                begin
                    phase = PH_IDLE;
                    if (hb >= XCHG_CMD_BASE)
                    begin
                        run_left = 7'((hb & RUN_LEN_MASK) + 8'd1);
                        phase = (hb >= WRITE_CMD_BASE) ? PH_WRITE : PH_XCHG;
                    end
                    else
                    begin
                        case (hb)
                            CMD_SELECT:   select_q = 1'b1;
                            CMD_UNSELECT: select_q = 1'b0;
                            CMD_ECHO:     phase = PH_ECHO;
                            CMD_LINE_A:   phase = PH_LINEA;
                            CMD_LINE_B:   phase = PH_LINEB;
                            CMD_MODE:     phase = PH_MODE;
                            default:      r.bad_command = 1'b1;
                        endcase
                    end
                end
            endcase
            r.select_active = select_q;
            r.line_a        = line_a_q;
            r.line_b        = line_b_q;
            r.bus_mode      = mode_q;
            return r;
        endfunction

        function void note_host_byte(logic [7:0] hb, logic [7:0] mb);
            result_t r;
            r = parse_host_byte(hb, mb);
            expected_beats.push_back(r);
            n_spi   += r.spi_valid;
            n_reply += r.reply_valid;
            n_bad   += r.bad_command;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            errors++;
            $display("%0t ns: beat %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, n_checked, what, got, want);
        endtask

        task check_beat(result_t got);
            result_t want;
            if (expected_beats.size() == 0)
            begin
                report_mismatch("beat with nothing pending", got, 0);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.reply_valid !== want.reply_valid)
                    report_mismatch("reply_valid", got.reply_valid, want.reply_valid);
                if (got.reply_byte !== want.reply_byte)
                    report_mismatch("reply_byte", got.reply_byte, want.reply_byte);
                if (got.spi_valid !== want.spi_valid)
                    report_mismatch("spi_valid", got.spi_valid, want.spi_valid);
                if (got.mosi_byte !== want.mosi_byte)
                    report_mismatch("mosi_byte", got.mosi_byte, want.mosi_byte);
                if (got.select_active !== want.select_active)
                    report_mismatch("select_active", got.select_active, want.select_active);
                if (got.line_a !== want.line_a)
                    report_mismatch("line_a", got.line_a, want.line_a);
                if (got.line_b !== want.line_b)
                    report_mismatch("line_b", got.line_b, want.line_b);
                if (got.bus_mode !== want.bus_mode)
                    report_mismatch("bus_mode", got.bus_mode, want.bus_mode);
                if (got.bad_command !== want.bad_command)
                    report_mismatch("bad_command", got.bad_command, want.bad_command);
            end
            n_checked++;
        endtask
    endclass

    // clock, reset and dut ports; the driven ones are known from time zero
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // host_byte[7:0], miso_byte[15:8]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // reply_valid[0], reply_byte[8:1], spi_valid[9], mosi_byte[17:10],
    // select_active[18], line_a[19], line_b[20], bus_mode[22:21], bad_command[23]
    logic [23:0] m_tdata;

    bridge_scoreboard sb;

    // traffic shaping shared by both sides
    bit calm;            // no gaps on either side for a stretch
    bit burst;           // sender only: back-to-back beats
    bit hold_requested;  // sink: start one long hold-off
    int n_sent;
    int n_holds;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    uart_spi_bridge_command_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // run lengths: mostly short, sometimes medium, now and then up to the full 64
    function automatic int pick_run_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 4);
        else if (r < 97)
            return $urandom_range(5, 16);
        else if (r < 99)
            return RUN_LEN_MAX;
        else
            return $urandom_range(17, RUN_LEN_MAX);
    endfunction

    // hold one beat on the slave side until it is taken
    task automatic send_beat(input logic [7:0] hb, input logic [7:0] mb);
        s_tvalid <= 1'b1;
        s_tdata  <= {mb, hb};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_host_byte(hb, mb);
        n_sent++;
    endtask

    // valid drops only when a real gap follows, so it is never lowered and raised in one step
    task automatic pause_sender();
        int n;
        n = (calm || burst) ? 0 : pick_gap();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_item(input logic [7:0] hb, input logic [7:0] mb);
        send_beat(hb, mb);
        pause_sender();
    endtask

    // run command of len bytes followed by n_data data beats (fewer breaks the sequence)
    task automatic send_run(input logic [7:0] base, input int len, input int n_data);
        send_item(base | 8'(len - 1), rand_byte());
        repeat (n_data) send_item(rand_byte(), rand_byte());
    endtask

    // stop offering and let every owed result come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_sequence();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            send_item(CMD_SELECT, rand_byte());
        else if (pick < 16)
            send_item(CMD_UNSELECT, rand_byte());
        else if (pick < 26)
        begin
            send_item(CMD_ECHO, rand_byte());
            send_item(rand_byte(), rand_byte());
        end
        else if (pick < 40)
        begin
            // line argument mostly 0 or 1, sometimes any byte (only bit 0 counts)
            send_item(($urandom_range(0, 1) != 0) ? CMD_LINE_A : CMD_LINE_B, rand_byte());
            send_item(($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 1)) : rand_byte(),
                      rand_byte());
        end
        else if (pick < 50)
        begin
            // mode argument mostly legal, sometimes above three
            send_item(CMD_MODE, rand_byte());
            send_item(($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(4, 255)),
                      rand_byte());
        end
        else if (pick < 68)
        begin
            len = pick_run_len();
            send_run(WRITE_CMD_BASE, len, len);
        end
        else if (pick < 86)
        begin
            len = pick_run_len();
            send_run(XCHG_CMD_BASE, len, len);
        end
        else if (pick < 92)
        begin
            // cut-short run: what follows is taken as run data
            len = pick_run_len();
            send_run(($urandom_range(0, 1) != 0) ? WRITE_CMD_BASE : XCHG_CMD_BASE,
                     len, $urandom_range(0, len - 1));
        end
        else
        begin
            send_item(($urandom_range(0, 3) == 0) ? CMD_STATUS : rand_byte(), rand_byte());
        end
    endtask

    // sink holds the output back while the sender keeps pushing, then everything drains
    task automatic apply_backpressure();
        hold_requested = 1'b1;
        burst = 1'b1;
        repeat (BURST_BEATS) send_item(rand_byte(), rand_byte());
        burst = 1'b0;
        wait_drained();
    endtask

    // stimulus
    initial
    begin : stimulus
        int next_hold_at;
        sb = new();
        next_hold_at = 300;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown commands incl. the status query, then select and an echo
        send_item(BYTE_NUL, 8'hff);
        send_item(CMD_STATUS, 8'h00);
        send_item(BYTE_DEL, 8'h00);
        send_item(CMD_SELECT, 8'ha5);
        send_item(CMD_ECHO, 8'h00);
        send_item(8'hff, 8'h00);
        // line arguments other than 0 or 1 use bit 0 only
        send_item(CMD_LINE_A, 8'h00);
        send_item(8'h02, 8'h00);
        send_item(CMD_LINE_B, 8'h00);
        send_item(8'hfe, 8'h00);
        send_item(CMD_LINE_A, 8'h00);
        send_item(8'h01, 8'h00);
        send_item(CMD_MODE, 8'h00);
        send_item(8'h03, 8'h00);
        // mode argument above three is flagged and the mode stays
        send_item(CMD_MODE, 8'h00);
        send_item(8'h04, 8'h00);
        send_item(CMD_MODE, 8'h00);
        send_item(8'hff, 8'h00);
        // single-byte exchange, miso all ones
        send_item(XCHG_CMD_BASE, 8'h00);
        send_item(8'h5a, 8'hff);
        // write run after select is released: still shifted out
        send_item(CMD_UNSELECT, 8'h00);
        send_item(WRITE_CMD_BASE | 8'h01, 8'hff);
        send_item(8'h00, 8'h00);
        send_item(8'hff, 8'hff);
        wait_drained();

        // random part: calm stretches every third block, two pressure points
        while (n_sent < RANDOM_ITEMS)
        begin
            calm = ((n_sent / 150) % 3) == 2;
            if (n_sent >= next_hold_at)
            begin
                calm = 1'b0;
                apply_backpressure();
                next_hold_at += 500;
            end
            send_random_sequence();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d host beats, %0d result beats checked: %0d spi bytes,",
                 n_sent, sb.n_checked, sb.n_spi);
        $display("%0d replies, %0d flagged bytes, %0d long output holds, %0d mismatches",
                 sb.n_reply, sb.n_bad, n_holds, sb.errors);
        if (sb.errors == 0)
            $display("** uart_spi_bridge_command_parser: PASSED **");
        else
            $display("** uart_spi_bridge_command_parser: FAILED **");
        $finish;
    end

    // result sink: checks every taken beat and drives ready with random gaps
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_beat(result_t'(m_tdata));
            if (hold_requested)
            begin
                hold_left = HOLD_CYCLES;
                hold_requested = 1'b0;
                n_holds++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin : watchdog
        #10_000_000;
        $display("timeout with %0d result beats still owed", sb.pending());
        $display("** uart_spi_bridge_command_parser: FAILED **");
        $finish;
    end

endmodule
